@@ sv/wmdc_pkg.sv @@
// ----------------------------------------------------------------------------
// wmdc_pkg
// Types and constants shared by the window mean deviation checker modules.
// ----------------------------------------------------------------------------
package wmdc_pkg;

    localparam int SAMPLE_W  = 16;   // sample, mean, deviation and step width
    localparam int SLOT_W    = 6;    // slot index width on the result
    localparam int SUM_W     = 22;   // running window sum
    localparam int PERM_W    = 10;   // per-mille tolerance registers
    localparam int LIM_W     = 26;   // products scaled by 1000
    localparam int CFG_IDX_W = 2;
    localparam int IN_W      = 16;   // s_tdata width
    localparam int OUT_W     = 80;   // m_tdata width

    localparam logic [LIM_W-1:0]  PERMILLE_SCALE = 26'd1000;
    localparam logic [PERM_W-1:0] LEVEL_TOL_RESET = 10'd100;
    localparam logic [PERM_W-1:0] STEP_TOL_RESET  = 10'd150;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_TOL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TOL  = 2'd1;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_DIV_START,
        ST_DIVIDE,
        ST_LIMITS,
        ST_FETCH,
        ST_LOAD,
        ST_NEXT,
        ST_EVAL
    } state_t;

    typedef enum logic {
        PASS_SCAN,
        PASS_EMIT
    } pass_t;

    // controller to datapath
    typedef struct packed {
        logic              sample_wr;
        logic              sum_clr;
        logic              div_start;
        logic              lim_load;
        logic              cur_load;
        logic              rd_en;
        logic              scan_acc;
        logic              out_load;
        logic              last_slot;
        logic [SLOT_W-1:0] slot;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_busy;
        logic out_free;
    } dp_status_t;

    // result word, first field in the highest bits
    typedef struct packed {
        logic [6:0]          pad;
        logic                any_problem;
        logic [SAMPLE_W-1:0] step_mv;
        logic                step_outlier;
        logic [SAMPLE_W-1:0] deviation_mv;
        logic                level_outlier;
        logic [SAMPLE_W-1:0] mean_value;
        logic [SAMPLE_W-1:0] sample_value;
        logic [SLOT_W-1:0]   slot_index;
    } out_item_t;

endpackage

@@ sv/wmdc_ram.sv @@
// ----------------------------------------------------------------------------
// wmdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wmdc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 6
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/wmdc_div.sv @@
// ----------------------------------------------------------------------------
// wmdc_div
// Divider of the window sum by a constant: register the sum, then multiply
// by a fixed reciprocal, shift and register the quotient.
// ----------------------------------------------------------------------------
module wmdc_div
    import wmdc_pkg::*;
#(
    parameter int DIVISOR = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    output logic             busy,
    output logic [SUM_W-1:0] quotient
);

    // with SHIFT = SUM_W + ceil(log2(DIVISOR)) and RECIP = ceil(2^SHIFT / DIVISOR),
    // (x * RECIP) >> SHIFT equals floor(x / DIVISOR) for every SUM_W-bit x
    localparam int SHIFT   = SUM_W + $clog2(DIVISOR);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1))
                 / longint'(DIVISOR));

    logic              busy_reg;
    logic [SUM_W-1:0]  arg_reg;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [PROD_W-1:0] prod;

    assign prod     = PROD_W'(arg_reg) * PROD_W'(RECIP);
    assign quo_next = SUM_W'(prod >> SHIFT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= start;
        end
        if (start) begin
            arg_reg <= dividend;
        end
        if (busy_reg) begin
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

@@ sv/wmdc_dp.sv @@
// ----------------------------------------------------------------------------
// wmdc_dp
// Datapath: sample store, window sum, mean divider, tolerance limits,
// outlier evaluation and the result register.
// ----------------------------------------------------------------------------
module wmdc_dp
    import wmdc_pkg::*;
#(
    parameter int WINDOW = 6
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ctrl_cmd_t                 cmd,
    input  logic [$clog2(WINDOW)-1:0] wr_addr,
    input  logic [$clog2(WINDOW)-1:0] rd_addr,
    output dp_status_t                status,
    input  logic [SAMPLE_W-1:0]       sample_in,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [PERM_W-1:0]         cfg_wr_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output out_item_t                 out_item,
    output logic                      out_last
);

    logic [PERM_W-1:0]   lvl_perm_reg, stp_perm_reg;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SUM_W-1:0]    quotient;
    logic                div_busy;
    logic [SAMPLE_W-1:0] mean;
    logic [LIM_W-1:0]    lvl_lim_reg, stp_lim_reg;
    logic [SAMPLE_W-1:0] rd_data;
    logic [SAMPLE_W-1:0] cur_reg;
    logic                any_reg, any_next;
    logic [SAMPLE_W-1:0] dev, step_abs, step;
    logic                lo, so;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_item_reg;
    logic                out_last_reg;

    wmdc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (cmd.sample_wr),
        .wr_addr (wr_addr),
        .wr_data (sample_in),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    wmdc_div #(
        .DIVISOR (WINDOW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign mean = quotient[SAMPLE_W-1:0];

    always_comb begin
        sum_next = sum_reg;
        if (cmd.sum_clr) begin
            sum_next = '0;
        end else if (cmd.sample_wr) begin
            sum_next = sum_reg + SUM_W'(sample_in);
        end
    end

    // evaluation of slot k: cur_reg holds sample k, rd_data holds sample k+1
    assign dev      = (cur_reg >= mean) ? (cur_reg - mean) : (mean - cur_reg);
    assign step_abs = (cur_reg >= rd_data) ? (cur_reg - rd_data) : (rd_data - cur_reg);
    assign step     = cmd.last_slot ? '0 : step_abs;
    assign lo       = (LIM_W'(dev) * PERMILLE_SCALE) > lvl_lim_reg;
    assign so       = !cmd.last_slot && ((LIM_W'(step) * PERMILLE_SCALE) > stp_lim_reg);

    always_comb begin
        any_next = any_reg;
        if (cmd.lim_load) begin
            any_next = 1'b0;
        end else if (cmd.scan_acc) begin
            any_next = any_reg | lo | so;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_perm_reg  <= LEVEL_TOL_RESET;
            stp_perm_reg  <= STEP_TOL_RESET;
            sum_reg       <= '0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_LEVEL_TOL: lvl_perm_reg <= cfg_wr_data;
                    CFG_STEP_TOL:  stp_perm_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            sum_reg       <= sum_next;
            any_reg       <= any_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lim_load) begin
            lvl_lim_reg <= LIM_W'(mean) * LIM_W'(lvl_perm_reg);
            stp_lim_reg <= LIM_W'(mean) * LIM_W'(stp_perm_reg);
        end
        if (cmd.cur_load) begin
            cur_reg <= rd_data;
        end
        if (cmd.out_load) begin
            out_item_reg.pad           <= '0;
            out_item_reg.any_problem   <= any_reg;
            out_item_reg.step_mv       <= step;
            out_item_reg.step_outlier  <= so;
            out_item_reg.deviation_mv  <= dev;
            out_item_reg.level_outlier <= lo;
            out_item_reg.mean_value    <= mean;
            out_item_reg.sample_value  <= cur_reg;
            out_item_reg.slot_index    <= cmd.slot;
            out_last_reg               <= cmd.last_slot;
        end
    end

    assign status.div_busy = div_busy;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_item        = out_item_reg;
    assign out_last        = out_last_reg;

endmodule

@@ sv/wmdc_ctrl.sv @@
// ----------------------------------------------------------------------------
// wmdc_ctrl
// Controller: collects the window, runs the mean divider, then walks the
// store twice, once to find any outlier and once to emit the results.
// ----------------------------------------------------------------------------
module wmdc_ctrl
    import wmdc_pkg::*;
#(
    parameter int WINDOW = 6
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  dp_status_t                status,
    output ctrl_cmd_t                 cmd,
    output logic [$clog2(WINDOW)-1:0] wr_addr,
    output logic [$clog2(WINDOW)-1:0] rd_addr
);

    localparam int AW = $clog2(WINDOW);
    localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW - 1);

    state_t        state_reg, state_next;
    pass_t         pass_reg, pass_next;
    logic [AW-1:0] fill_reg, fill_next;
    logic [AW-1:0] k_reg, k_next;
    logic          last_slot;
    logic          eval_go;

    assign last_slot = (k_reg == LAST_IDX);
    // the scan pass never waits; the emit pass waits for a free result register
    assign eval_go   = (pass_reg == PASS_SCAN) || status.out_free;

    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        fill_next  = fill_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_COLLECT: begin
                if (s_tvalid) begin
                    if (fill_reg == LAST_IDX) begin
                        fill_next  = '0;
                        state_next = ST_DIV_START;
                    end else begin
                        fill_next = fill_reg + AW'(1);
                    end
                end
            end
            ST_DIV_START: begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (!status.div_busy) begin
                    state_next = ST_LIMITS;
                end
            end
            ST_LIMITS: begin
                pass_next  = PASS_SCAN;
                k_next     = '0;
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = ST_NEXT;
            end
            ST_NEXT: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (eval_go) begin
                    if (last_slot) begin
                        k_next = '0;
                        if (pass_reg == PASS_SCAN) begin
                            pass_next  = PASS_EMIT;
                            state_next = ST_FETCH;
                        end else begin
                            state_next = ST_COLLECT;
                        end
                    end else begin
                        k_next     = k_reg + AW'(1);
                        state_next = ST_NEXT;
                    end
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_comb begin
        cmd           = '0;
        cmd.last_slot = last_slot;
        cmd.slot      = SLOT_W'(k_reg);
        rd_addr       = k_reg;
        s_tready      = 1'b0;
        case (state_reg)
            ST_COLLECT: begin
                s_tready      = 1'b1;
                cmd.sample_wr = s_tvalid;
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                cmd.sum_clr   = 1'b1;
            end
            ST_LIMITS: begin
                cmd.lim_load = 1'b1;
            end
            ST_FETCH: begin
                cmd.rd_en = 1'b1;
            end
            ST_LOAD: begin
                cmd.cur_load = 1'b1;
            end
            ST_NEXT: begin
                // fetch the neighbor for the step check
                rd_addr   = k_reg + AW'(1);
                cmd.rd_en = !last_slot;
            end
            ST_EVAL: begin
                cmd.scan_acc = (pass_reg == PASS_SCAN);
                cmd.out_load = (pass_reg == PASS_EMIT) && status.out_free;
                cmd.cur_load = eval_go;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
            pass_reg  <= PASS_SCAN;
            fill_reg  <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            fill_reg  <= fill_next;
            k_reg     <= k_next;
        end
    end

    assign wr_addr = fill_reg;

    a_div_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> status.div_busy)
        else $error("divider did not start");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result register overwritten");

    a_no_input_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_COLLECT) |-> !cmd.sample_wr)
        else $error("sample written outside collection");

    a_emit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL && pass_reg == PASS_EMIT && last_slot && status.out_free)
        |=> (state_reg == ST_COLLECT && fill_reg == '0))
        else $error("window not restarted after last result");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (k_reg <= LAST_IDX) && (fill_reg <= LAST_IDX))
        else $error("slot counter out of range");

endmodule

@@ sv/window_mean_deviation_checker.sv @@
// ----------------------------------------------------------------------------
// window_mean_deviation_checker
// Window mean with level and step outlier checks on voltage samples.
// ----------------------------------------------------------------------------
// Usage:
//   Samples (mV) enter on the s_ stream. Every WINDOW samples form a window;
//   after the sample that fills it, the block divides the window sum by
//   WINDOW, forms both tolerance limits, scans the stored samples once for
//   outliers and then sends one result per slot on the m_ stream, slot 0
//   first, with m_tlast on the final slot.
//   Timing: s_tready is high only while a window is being collected, one
//   sample a cycle. The mean comes from a reciprocal multiplication, and
//   each walk over the store reads each slot's neighbor for the step
//   check through the single RAM read port.
//   A stalled m_tready holds the current result and pauses the walk; no
//   result is dropped. Reset empties the window and loads the tolerance
//   registers with 100 and 150 per mille. Write configuration only between
//   windows, through cfg_wr_en / cfg_wr_index / cfg_wr_data.
// ----------------------------------------------------------------------------
module window_mean_deviation_checker
    import wmdc_pkg::*;
#(
    parameter int WINDOW = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,      // sample_mv[15:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // slot_index[5:0], sample_value[21:6], mean_value[37:22], level_outlier[38],
    // deviation_mv[54:39], step_outlier[55], step_mv[71:56], any_problem[72]
    output logic [OUT_W-1:0]     m_tdata,
    output logic                 m_tlast,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [PERM_W-1:0]    cfg_wr_data
);

    localparam int AW = $clog2(WINDOW);

    ctrl_cmd_t     cmd;
    dp_status_t    status;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    out_item_t     out_item;

    wmdc_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr)
    );

    wmdc_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr),
        .status       (status),
        .sample_in    (s_tdata[SAMPLE_W-1:0]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_item     (out_item),
        .out_last     (m_tlast)
    );

    assign m_tdata = OUT_W'(out_item);

endmodule
